/* rtl/rc4_keystream_cipher_core_defines.svh */
// Assertion macros used by the RC4 core checker.
// No dependencies; taken in by `include.
`ifndef RC4_KEYSTREAM_CIPHER_CORE_DEFINES_SVH
`define RC4_KEYSTREAM_CIPHER_CORE_DEFINES_SVH

// Checked only while out of reset.
`define RC4_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define RC4_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/rc4_pkg.sv */
// Shared types and constants for the RC4 keystream core.
// No dependencies.
`default_nettype none

package rc4_pkg;

    localparam int KEY_MAX_DEF = 256;
    localparam int LEN_W       = 9;

    localparam logic [LEN_W-1:0] KEY_LEN_RST = 9'd16;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_SCHED = 2'd1;
    localparam logic [1:0] MODE_ENC   = 2'd2;

    typedef struct packed {
        logic       valid;
        logic [1:0] mode;
        logic [7:0] key_index;
        logic [7:0] data_byte;
    } t_eng_req;

    typedef struct packed {
        logic       done;
        logic [7:0] keystream_byte;
        logic [7:0] cipher_byte;
        logic       status;
    } t_eng_rsp;

endpackage

`default_nettype wire

/* rtl/rc4_in_if.sv */
// Request channel of the RC4 core: mode, key index and data byte.
// No dependencies.
`default_nettype none

interface rc4_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] key_index;
    logic [7:0] data_byte;

    modport source (output valid, output mode, output key_index, output data_byte,
                    input ready);
    modport sink   (input valid, input mode, input key_index, input data_byte,
                    output ready);
endinterface

`default_nettype wire

/* rtl/rc4_out_if.sv */
// Result channel of the RC4 core: keystream, cipher byte and status.
// No dependencies.
`default_nettype none

interface rc4_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] keystream_byte;
    logic [7:0] cipher_byte;
    logic       status;

    modport source (output valid, output keystream_byte, output cipher_byte,
                    output status, input ready);
    modport sink   (input valid, input keystream_byte, input cipher_byte,
                    input status, output ready);
endinterface

`default_nettype wire

/* rtl/rc4_cfg_if.sv */
// Configuration write channel of the RC4 core (key length register).
// Depends on rc4_pkg.
`default_nettype none

interface rc4_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [rc4_pkg::LEN_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/rc4_engine.sv */
// RC4 sequencer: permutation and key memories, one shared index adder/swap path.
// Depends on rc4_pkg.
`default_nettype none

module rc4_engine #(
    parameter int KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rc4_pkg::t_eng_req          i_req,
    input  logic [rc4_pkg::LEN_W-1:0]  i_key_len,
    input  logic                       i_ack,
    output logic                       o_idle,
    output rc4_pkg::t_eng_rsp          o_rsp
);

    localparam int KW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int LW = rc4_pkg::LEN_W;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_INIT = 8'b0000_0010,
        ST_RD_I = 8'b0000_0100,
        ST_RD_J = 8'b0000_1000,
        ST_WR_I = 8'b0001_0000,
        ST_WR_J = 8'b0010_0000,
        ST_RD_T = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } t_state;

    logic [7:0] r_perm [256];
    logic [7:0] r_key  [KEY_MAX];
    logic [7:0] r_perm_rd;
    logic [7:0] r_key_rd;

    t_state          r_state, n_state;
    logic [7:0]      r_i, n_i;
    logic [7:0]      r_j, n_j;
    logic [KW-1:0]   r_k, n_k;
    logic            r_keyed, n_keyed;
    logic            r_sched, n_sched;
    logic [7:0]      r_si, n_si;
    logic [7:0]      r_sj, n_sj;
    logic [7:0]      r_data, n_data;
    logic            r_enc, n_enc;
    logic            r_status, n_status;

    logic            perm_we;
    logic            perm_re;
    logic [7:0]      perm_wa;
    logic [7:0]      perm_wd;
    logic [7:0]      perm_ra;
    logic            key_we;
    logic [7:0]      j_sum;
    logic            k_last;
    logic            key_in_range;

    // shared adder: j + S[i] (+ key byte while scheduling)
    assign j_sum  = r_j + r_perm_rd + (r_sched ? r_key_rd : 8'd0);
    assign k_last = ((LW'(r_k) + LW'(1)) >= i_key_len);
    assign key_in_range = ({1'b0, i_req.key_index} < LW'(KEY_MAX));

    always_ff @(posedge i_clk) begin
        if (perm_we) begin
            r_perm[perm_wa] <= perm_wd;
        end
        if (perm_re) begin
            r_perm_rd <= r_perm[perm_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key[i_req.key_index[KW-1:0]] <= i_req.data_byte;
        end
        r_key_rd <= r_key[r_k];
    end

    always_comb begin
        n_state  = r_state;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_keyed  = r_keyed;
        n_sched  = r_sched;
        n_si     = r_si;
        n_sj     = r_sj;
        n_data   = r_data;
        n_enc    = r_enc;
        n_status = r_status;
        perm_we  = 1'b0;
        perm_re  = 1'b0;
        perm_wa  = r_i;
        perm_wd  = r_i;
        perm_ra  = r_i;
        key_we   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_enc    = 1'b0;
                    n_status = 1'b0;
                    n_state  = ST_DONE;
                    case (i_req.mode)
                        rc4_pkg::MODE_LOAD: begin
                            key_we = key_in_range;
                        end
                        rc4_pkg::MODE_SCHED: begin
                            n_i     = 8'd0;
                            n_j     = 8'd0;
                            n_k     = '0;
                            n_sched = 1'b1;
                            n_state = ST_INIT;
                        end
                        rc4_pkg::MODE_ENC: begin
                            if (!r_keyed) begin
                                n_status = 1'b1;
                            end else begin
                                n_i     = r_i + 8'd1;
                                n_data  = i_req.data_byte;
                                n_sched = 1'b0;
                                n_enc   = 1'b1;
                                n_state = ST_RD_I;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_INIT: begin
                // identity fill, one entry a cycle
                perm_we = 1'b1;
                n_i     = r_i + 8'd1;
                if (r_i == 8'hFF) begin
                    n_state = ST_RD_I;
                end
            end
            ST_RD_I: begin
                perm_re = 1'b1;
                n_state = ST_RD_J;
            end
            ST_RD_J: begin
                n_si    = r_perm_rd;
                n_j     = j_sum;
                perm_re = 1'b1;
                perm_ra = j_sum;
                n_state = ST_WR_I;
            end
            ST_WR_I: begin
                n_sj    = r_perm_rd;
                perm_we = 1'b1;
                perm_wd = r_perm_rd;
                n_state = ST_WR_J;
            end
            ST_WR_J: begin
                perm_we = 1'b1;
                perm_wa = r_j;
                perm_wd = r_si;
                if (r_sched) begin
                    n_k = k_last ? '0 : r_k + KW'(1);
                    n_i = r_i + 8'd1;
                    if (r_i == 8'hFF) begin
                        // i wraps to zero; clear j and mark keyed
                        n_j     = 8'd0;
                        n_keyed = 1'b1;
                        n_sched = 1'b0;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_RD_I;
                    end
                end else begin
                    n_state = ST_RD_T;
                end
            end
            ST_RD_T: begin
                perm_re = 1'b1;
                perm_ra = r_si + r_sj;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_ack) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= 8'd0;
            r_j     <= 8'd0;
            r_k     <= '0;
            r_keyed <= 1'b0;
            r_sched <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_keyed <= n_keyed;
            r_sched <= n_sched;
        end
    end

    always_ff @(posedge i_clk) begin
        r_si     <= n_si;
        r_sj     <= n_sj;
        r_data   <= n_data;
        r_enc    <= n_enc;
        r_status <= n_status;
    end

    assign o_idle               = (r_state == ST_IDLE);
    assign o_rsp.done           = (r_state == ST_DONE);
    assign o_rsp.keystream_byte = r_enc ? r_perm_rd : 8'd0;
    assign o_rsp.cipher_byte    = r_enc ? (r_perm_rd ^ r_data) : 8'd0;
    assign o_rsp.status         = r_status;

endmodule

`default_nettype wire

/* rtl/rc4_keystream_cipher_core.sv */
// Top level of the RC4 keystream core: key length register and result register.
// Depends on rc4_pkg, rc4_in_if, rc4_out_if, rc4_cfg_if and rc4_engine.
`default_nettype none

// RC4 keystream core. Each request carries a mode: load one key byte, run the
// key schedule, or encrypt one data byte. Every request returns exactly one
// result; only encrypt returns non-zero bytes, and status is set when
// encrypting before any schedule has run. One request is worked at a time.
// A key load, an unused mode or an unkeyed encrypt passes straight to the
// result; a keyed encrypt reads S[i] and S[j], writes the swap back and reads
// the keystream byte; the key schedule makes 256 identity writes, then 256
// swaps of two reads and two writes each, then passes the result out.
// These steps are set by the one read and one write port of the 256-byte
// permutation memory, which the sequencer uses for every read and swap write.
// A finished result waits in the output register, so the next request is
// taken while it is still pending. The key length register may be written
// only while no request is in progress; 0 means one byte, values above the
// key store depth are clipped to it.

module rc4_keystream_cipher_core #(
    parameter int KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rc4_in_if.sink    i_in_chan,
    rc4_out_if.source o_out_chan,
    rc4_cfg_if.sink   i_cfg_chan
);

    localparam int LW = rc4_pkg::LEN_W;

    logic [LW-1:0]      r_key_length;
    logic [LW-1:0]      eff_len;
    logic               r_out_valid;
    logic [7:0]         r_out_ks;
    logic [7:0]         r_out_ct;
    logic               r_out_status;
    logic               eng_idle;
    logic               eng_ack;
    rc4_pkg::t_eng_req  eng_req;
    rc4_pkg::t_eng_rsp  eng_rsp;

    assign i_cfg_chan.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length <= rc4_pkg::KEY_LEN_RST;
        end else if (i_cfg_chan.valid) begin
            r_key_length <= i_cfg_chan.data;
        end
    end

    always_comb begin
        if (r_key_length == '0) begin
            eff_len = LW'(1);
        end else if (r_key_length > LW'(KEY_MAX)) begin
            eff_len = LW'(KEY_MAX);
        end else begin
            eff_len = r_key_length;
        end
    end

    assign i_in_chan.ready   = eng_idle;
    assign eng_req.valid     = i_in_chan.valid & eng_idle;
    assign eng_req.mode      = i_in_chan.mode;
    assign eng_req.key_index = i_in_chan.key_index;
    assign eng_req.data_byte = i_in_chan.data_byte;

    rc4_engine #(
        .KEY_MAX (KEY_MAX)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (eng_req),
        .i_key_len (eff_len),
        .i_ack     (eng_ack),
        .o_idle    (eng_idle),
        .o_rsp     (eng_rsp)
    );

    // result moves across when the output register is free or being drained
    assign eng_ack = eng_rsp.done & (~r_out_valid | o_out_chan.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_ack) begin
            r_out_valid <= 1'b1;
        end else if (o_out_chan.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_ack) begin
            r_out_ks     <= eng_rsp.keystream_byte;
            r_out_ct     <= eng_rsp.cipher_byte;
            r_out_status <= eng_rsp.status;
        end
    end

    assign o_out_chan.valid          = r_out_valid;
    assign o_out_chan.keystream_byte = r_out_ks;
    assign o_out_chan.cipher_byte    = r_out_ct;
    assign o_out_chan.status         = r_out_status;

endmodule

`default_nettype wire

/* rtl/rc4_checker.sv */
// Port-level checks for the RC4 keystream core, bound to the top level.
// Depends on rc4_keystream_cipher_core_defines.svh and rc4_keystream_cipher_core.
`default_nettype none
`include "rc4_keystream_cipher_core_defines.svh"

module rc4_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_ks,
    input logic [7:0] i_out_ct,
    input logic       i_out_status
);

    // after reset the block is idle with nothing pending
    `RC4_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> i_in_ready && !i_out_valid, "not idle after reset")

    // one request at a time: busy right after acceptance
    `RC4_ASSERT(a_busy_after_req, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready, "request accepted while busy")

    // a not-keyed status carries no keystream
    `RC4_ASSERT(a_status_zero, i_clk, i_rst_n, i_out_valid && i_out_status |-> i_out_ks == 8'd0 && i_out_ct == 8'd0, "status result with data")

    // a stalled result holds
    `RC4_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_ks) && $stable(i_out_ct), "stalled result changed")

endmodule

bind rc4_keystream_cipher_core rc4_checker u_rc4_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_chan.valid),
    .i_in_ready   (i_in_chan.ready),
    .i_out_valid  (o_out_chan.valid),
    .i_out_ready  (o_out_chan.ready),
    .i_out_ks     (o_out_chan.keystream_byte),
    .i_out_ct     (o_out_chan.cipher_byte),
    .i_out_status (o_out_chan.status)
);

`default_nettype wire
